// ===== rtl/lfcs_pkg.sv =====
// Package for the LED flash-code sequencer.
// Holds the operation codes, register indexes, reset values and the shared structs.
// No dependencies.
`default_nettype none

package lfcs_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_REQUEST  = 2'd1,
        OP_OVERRIDE = 2'd2,
        OP_SET_LAMP = 2'd3
    } lfcs_op_t;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_TICK_PRESCALE       = 3'd0,
        REG_LONG_ON_STEPS       = 3'd1,
        REG_LONG_GAP_STEPS      = 3'd2,
        REG_LONG_END_GAP_STEPS  = 3'd3,
        REG_SHORT_ON_STEPS      = 3'd4,
        REG_SHORT_OFF_STEPS     = 3'd5,
        REG_PATTERN_PAUSE_STEPS = 3'd6
    } lfcs_reg_t;

    localparam logic [CfgDataWidth-1:0] RST_TICK_PRESCALE       = 8'd50;
    localparam logic [CfgDataWidth-1:0] RST_LONG_ON_STEPS       = 8'd12;
    localparam logic [CfgDataWidth-1:0] RST_LONG_GAP_STEPS      = 8'd4;
    localparam logic [CfgDataWidth-1:0] RST_LONG_END_GAP_STEPS  = 8'd6;
    localparam logic [CfgDataWidth-1:0] RST_SHORT_ON_STEPS      = 8'd3;
    localparam logic [CfgDataWidth-1:0] RST_SHORT_OFF_STEPS     = 8'd3;
    localparam logic [CfgDataWidth-1:0] RST_PATTERN_PAUSE_STEPS = 8'd24;

    typedef struct packed {
        logic [CfgDataWidth-1:0] tick_prescale;
        logic [CfgDataWidth-1:0] long_on_steps;
        logic [CfgDataWidth-1:0] long_gap_steps;
        logic [CfgDataWidth-1:0] long_end_gap_steps;
        logic [CfgDataWidth-1:0] short_on_steps;
        logic [CfgDataWidth-1:0] short_off_steps;
        logic [CfgDataWidth-1:0] pattern_pause_steps;
    } lfcs_cfg_t;

    typedef struct packed {
        logic led_on;
        logic pattern_active;
    } lfcs_result_t;

endpackage

`default_nettype wire

// ===== rtl/lfcs_seq.sv =====
// Sequencer state and step logic of the LED flash-code sequencer.
// Updates the counters once per accepted item and gives the resulting LED status.
// Depends on lfcs_pkg.
`default_nettype none

module lfcs_seq
    import lfcs_pkg::*;
#(
    parameter int COUNTER_WIDTH = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [1:0]   operation,
    input  wire logic [7:0]   code,
    input  wire logic         lamp_value,
    input  wire lfcs_cfg_t    cfg,
    output lfcs_result_t      result
);

    logic [COUNTER_WIDTH-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNTER_WIDTH-1:0] on_count_reg, on_count_next;
    logic [COUNTER_WIDTH-1:0] off_count_reg, off_count_next;
    logic [3:0]               long_left_reg, long_left_next;
    logic [3:0]               short_left_reg, short_left_next;
    logic [7:0]               pending_code_reg, pending_code_next;
    logic                     lamp_enabled_reg, lamp_enabled_next;
    logic                     led_level_reg, led_level_next;

    logic [COUNTER_WIDTH-1:0] prescale_inc;
    logic                     step;
    logic [3:0]               long_after;
    logic [3:0]               short_after;
    lfcs_op_t                 op;

    assign op          = lfcs_op_t'(operation);
    assign prescale_inc = prescale_count_reg + COUNTER_WIDTH'(1);
    assign step        = (prescale_inc == COUNTER_WIDTH'(cfg.tick_prescale));
    assign long_after  = long_left_reg - 4'd1;
    assign short_after = short_left_reg - 4'd1;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        on_count_next       = on_count_reg;
        off_count_next      = off_count_reg;
        long_left_next      = long_left_reg;
        short_left_next     = short_left_reg;
        pending_code_next   = pending_code_reg;
        lamp_enabled_next   = lamp_enabled_reg;
        led_level_next      = led_level_reg;

        unique case (op)
            OP_TICK:
            begin
                prescale_count_next = step ? '0 : prescale_inc;
                if (step)
                begin
                    // Priority: on time, off time, long flashes, short flashes, pending code, lamp flag.
                    if (on_count_reg != '0)
                    begin
                        led_level_next = 1'b1;
                        on_count_next  = on_count_reg - COUNTER_WIDTH'(1);
                    end
                    else if (off_count_reg != '0)
                    begin
                        led_level_next = 1'b0;
                        off_count_next = off_count_reg - COUNTER_WIDTH'(1);
                    end
                    else if (long_left_reg != '0)
                    begin
                        long_left_next = long_after;
                        on_count_next  = COUNTER_WIDTH'(cfg.long_on_steps);
                        if (long_after != '0)
                            off_count_next = COUNTER_WIDTH'(cfg.long_gap_steps);
                        else if (short_left_reg != '0)
                            off_count_next = COUNTER_WIDTH'(cfg.long_end_gap_steps);
                        else
                            off_count_next = COUNTER_WIDTH'(cfg.pattern_pause_steps);
                    end
                    else if (short_left_reg != '0)
                    begin
                        short_left_next = short_after;
                        on_count_next   = COUNTER_WIDTH'(cfg.short_on_steps);
                        if (short_after != '0)
                            off_count_next = COUNTER_WIDTH'(cfg.short_off_steps);
                        else
                            off_count_next = COUNTER_WIDTH'(cfg.pattern_pause_steps);
                    end
                    else if (pending_code_reg != '0)
                    begin
                        long_left_next    = pending_code_reg[7:4];
                        short_left_next   = pending_code_reg[3:0];
                        pending_code_next = '0;
                    end
                    else if (lamp_enabled_reg)
                    begin
                        led_level_next = 1'b1;
                    end
                end
            end
            OP_REQUEST:
            begin
                if (pending_code_reg == '0)
                    pending_code_next = code;
            end
            OP_OVERRIDE:
            begin
                on_count_next     = '0;
                off_count_next    = '0;
                long_left_next    = '0;
                short_left_next   = '0;
                pending_code_next = code;
                led_level_next    = 1'b0;
            end
            OP_SET_LAMP:
            begin
                lamp_enabled_next = lamp_value;
                if (!lamp_value)
                    led_level_next = 1'b0;
            end
            default:
            begin
                led_level_next = led_level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            on_count_reg       <= '0;
            off_count_reg      <= '0;
            long_left_reg      <= '0;
            short_left_reg     <= '0;
            pending_code_reg   <= '0;
            lamp_enabled_reg   <= 1'b0;
            led_level_reg      <= 1'b0;
        end
        else if (accept)
        begin
            prescale_count_reg <= prescale_count_next;
            on_count_reg       <= on_count_next;
            off_count_reg      <= off_count_next;
            long_left_reg      <= long_left_next;
            short_left_reg     <= short_left_next;
            pending_code_reg   <= pending_code_next;
            lamp_enabled_reg   <= lamp_enabled_next;
            led_level_reg      <= led_level_next;
        end
    end

    // The result reflects the state after this item.
    assign result.led_on         = led_level_next;
    assign result.pattern_active = (on_count_next != '0) || (off_count_next != '0)
                                || (long_left_next != '0) || (short_left_next != '0)
                                || (pending_code_next != '0);

endmodule

`default_nettype wire

// ===== rtl/led_flash_code_sequencer.sv =====
// LED flash-code sequencer, usage:
// An item on the input channel (operation, code, lamp_value) transfers at a clock
// edge with in_valid high and in_stall low. Operation 0 is a base tick, 1 requests
// a code if none is pending, 2 overrides with a new code, 3 sets the lamp flag.
// Every item produces exactly one result (led_on, pattern_active) on the output
// channel, which transfers when out_valid is high and out_stall is low.
// An item's result is registered in the output register, or in the skid entry while
// that is full. Throughput is one item per cycle while in_stall is low; the
// sequencer state updates in one pass of logic between state and output registers.
// A two-entry output buffer lets one item be accepted while a result waits; when the
// receiver stalls and both entries are full, in_stall goes high until one drains.
// The configuration registers are written via cfg_we, cfg_index and cfg_data; the
// user must write only while the block is idle (not enforced); index 7 is ignored.
// Reset (rst_n low, asynchronous) clears all counters, the pending code, the lamp
// flag and the LED, empties the output buffer and loads the default register values.
// Depends on lfcs_pkg, lfcs_seq.
`default_nettype none

module led_flash_code_sequencer
    import lfcs_pkg::*;
#(
    parameter int COUNTER_WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               operation,
    input  wire logic [7:0]               code,
    input  wire logic                     lamp_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          led_on,
    output logic                          pattern_active,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    lfcs_cfg_t    cfg_reg;
    lfcs_result_t step_result;
    lfcs_result_t out_reg;
    lfcs_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         push;
    logic         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_prescale       <= RST_TICK_PRESCALE;
            cfg_reg.long_on_steps       <= RST_LONG_ON_STEPS;
            cfg_reg.long_gap_steps      <= RST_LONG_GAP_STEPS;
            cfg_reg.long_end_gap_steps  <= RST_LONG_END_GAP_STEPS;
            cfg_reg.short_on_steps      <= RST_SHORT_ON_STEPS;
            cfg_reg.short_off_steps     <= RST_SHORT_OFF_STEPS;
            cfg_reg.pattern_pause_steps <= RST_PATTERN_PAUSE_STEPS;
        end
        else if (cfg_we)
        begin
            unique case (lfcs_reg_t'(cfg_index))
                REG_TICK_PRESCALE:       cfg_reg.tick_prescale       <= cfg_data;
                REG_LONG_ON_STEPS:       cfg_reg.long_on_steps       <= cfg_data;
                REG_LONG_GAP_STEPS:      cfg_reg.long_gap_steps      <= cfg_data;
                REG_LONG_END_GAP_STEPS:  cfg_reg.long_end_gap_steps  <= cfg_data;
                REG_SHORT_ON_STEPS:      cfg_reg.short_on_steps      <= cfg_data;
                REG_SHORT_OFF_STEPS:     cfg_reg.short_off_steps     <= cfg_data;
                REG_PATTERN_PAUSE_STEPS: cfg_reg.pattern_pause_steps <= cfg_data;
                default:                 cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign in_stall = skid_valid_reg;
    assign push     = in_valid && !in_stall;
    assign pop      = out_valid_reg && !out_stall;

    lfcs_seq #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (push),
        .operation  (operation),
        .code       (code),
        .lamp_value (lamp_value),
        .cfg        (cfg_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            // A full skid entry blocks new transfers, so only one source refills.
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_result;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_reg <= step_result;
            else
                out_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_on         = out_reg.led_on;
    assign pattern_active = out_reg.pattern_active;

endmodule

`default_nettype wire

// ===== dv/led_flash_code_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LED flash-code sequencer: directed items, then phases of
// random codes and ticks under several register settings, checked against an inline predictor.
// Depends on lfcs_pkg and led_flash_code_sequencer.

module led_flash_code_sequencer_tb;
    import lfcs_pkg::*;

    typedef struct {
        lfcs_op_t   op;
        logic [7:0] code;
        logic       lamp;
    } flash_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = OP_TICK;
    logic [7:0]               code = 8'h00;
    logic                     lamp_value = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     led_on;
    logic                     pattern_active;
    logic                     cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = REG_TICK_PRESCALE;
    logic [CfgDataWidth-1:0]  cfg_data = 8'h00;

    flash_item_t  op_backlog[$];
    lfcs_result_t led_state_q[$];

    // Predictor state and its copy of the registers.
    lfcs_cfg_t  seq_cfg = '{RST_TICK_PRESCALE, RST_LONG_ON_STEPS, RST_LONG_GAP_STEPS,
                            RST_LONG_END_GAP_STEPS, RST_SHORT_ON_STEPS, RST_SHORT_OFF_STEPS,
                            RST_PATTERN_PAUSE_STEPS};
    logic [7:0] tick_cnt = 8'h00;
    logic [7:0] on_cnt = 8'h00;
    logic [7:0] off_cnt = 8'h00;
    logic [3:0] longs_left = 4'h0;
    logic [3:0] shorts_left = 4'h0;
    logic [7:0] queued_code = 8'h00;
    logic       lamp_flag = 1'b0;
    logic       led_level = 1'b0;

    bit took_input = 1'b0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int stall_gap = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int step_total = 0;
    int latch_total = 0;
    int long_total = 0;
    int short_total = 0;

    led_flash_code_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .code           (code),
        .lamp_value     (lamp_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_on         (led_on),
        .pattern_active (pattern_active),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // One sequencer step, in priority order: on, off, long flashes, short flashes, latch, lamp.
    function automatic void run_flash_step();
        step_total++;
        if (on_cnt != 0)
        begin
            led_level = 1'b1;
            on_cnt = on_cnt - 8'd1;
        end
        else if (off_cnt != 0)
        begin
            led_level = 1'b0;
            off_cnt = off_cnt - 8'd1;
        end
        else if (longs_left != 0)
        begin
            long_total++;
            longs_left = longs_left - 4'd1;
            on_cnt = seq_cfg.long_on_steps;
            if (longs_left != 0)
                off_cnt = seq_cfg.long_gap_steps;
            else if (shorts_left != 0)
                off_cnt = seq_cfg.long_end_gap_steps;
            else
                off_cnt = seq_cfg.pattern_pause_steps;
        end
        else if (shorts_left != 0)
        begin
            short_total++;
            shorts_left = shorts_left - 4'd1;
            on_cnt = seq_cfg.short_on_steps;
            off_cnt = (shorts_left == 0) ? seq_cfg.pattern_pause_steps : seq_cfg.short_off_steps;
        end
        else if (queued_code != 0)
        begin
            latch_total++;
            longs_left = queued_code[7:4];
            shorts_left = queued_code[3:0];
            queued_code = 8'h00;
        end
        else if (lamp_flag)
            led_level = 1'b1;
    endfunction

    function automatic lfcs_result_t predict_led(flash_item_t it);
        lfcs_result_t r;
        case (it.op)
            OP_TICK:
            begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt == seq_cfg.tick_prescale)
                begin
                    tick_cnt = 8'h00;
                    run_flash_step();
                end
            end
            OP_REQUEST:
                if (queued_code == 0)
                    queued_code = it.code;
            OP_OVERRIDE:
            begin
                on_cnt = 8'h00;
                off_cnt = 8'h00;
                longs_left = 4'h0;
                shorts_left = 4'h0;
                queued_code = it.code;
                led_level = 1'b0;
            end
            OP_SET_LAMP:
            begin
                lamp_flag = it.lamp;
                if (!it.lamp)
                    led_level = 1'b0;
            end
        endcase
        r.led_on = led_level;
        r.pattern_active = |{on_cnt, off_cnt, longs_left, shorts_left, queued_code};
        return r;
    endfunction

    // Input side: a new item is presented only once the previous one has made its transfer.
    always @(negedge clk)
    begin
        flash_item_t nxt;
        if (rst_n && (!in_valid || took_input))
        begin
            took_input = 1'b0;
            if (send_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
                send_gap = $urandom_range(1, 9);
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (op_backlog.size() != 0)
            begin
                nxt = op_backlog.pop_front();
                operation <= nxt.op;
                code <= nxt.code;
                lamp_value <= nxt.lamp;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side stall: random bursts, plus one long hold on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_gap > 0)
            begin
                stall_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 9) == 0)
                    stall_gap = $urandom_range(1, 9);
            end
        end
    end

    // Results are checked before the input transfer of the same edge is predicted.
    always @(posedge clk)
    begin
        lfcs_result_t want;
        flash_item_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (led_state_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: led_on=%0b pattern_active=%0b",
                             $time, led_on, pattern_active);
                    mismatch_count++;
                end
                else
                begin
                    want = led_state_q.pop_front();
                    result_count++;
                    if (led_on !== want.led_on)
                    begin
                        $display("%0t: led_on expected %0b, got %0b", $time, want.led_on, led_on);
                        mismatch_count++;
                    end
                    if (pattern_active !== want.pattern_active)
                    begin
                        $display("%0t: pattern_active expected %0b, got %0b",
                                 $time, want.pattern_active, pattern_active);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                seen.op = lfcs_op_t'(operation);
                seen.code = code;
                seen.lamp = lamp_value;
                led_state_q.push_back(predict_led(seen));
                took_input = 1'b1;
            end
        end
    end

    task automatic push_item(lfcs_op_t op, logic [7:0] c, logic lamp);
        flash_item_t it;
        it.op = op;
        it.code = c;
        it.lamp = lamp;
        op_backlog.push_back(it);
    endtask

    task automatic write_reg(lfcs_reg_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TICK_PRESCALE:       seq_cfg.tick_prescale = val;
            REG_LONG_ON_STEPS:       seq_cfg.long_on_steps = val;
            REG_LONG_GAP_STEPS:      seq_cfg.long_gap_steps = val;
            REG_LONG_END_GAP_STEPS:  seq_cfg.long_end_gap_steps = val;
            REG_SHORT_ON_STEPS:      seq_cfg.short_on_steps = val;
            REG_SHORT_OFF_STEPS:     seq_cfg.short_off_steps = val;
            REG_PATTERN_PAUSE_STEPS: seq_cfg.pattern_pause_steps = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [7:0] pre, logic [7:0] lon, logic [7:0] lgap,
                                 logic [7:0] lend, logic [7:0] son, logic [7:0] soff,
                                 logic [7:0] pause);
        write_reg(REG_TICK_PRESCALE, pre);
        write_reg(REG_LONG_ON_STEPS, lon);
        write_reg(REG_LONG_GAP_STEPS, lgap);
        write_reg(REG_LONG_END_GAP_STEPS, lend);
        write_reg(REG_SHORT_ON_STEPS, son);
        write_reg(REG_SHORT_OFF_STEPS, soff);
        write_reg(REG_PATTERN_PAUSE_STEPS, pause);
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || in_valid || led_state_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_code(int max_nib);
        logic [3:0] hi;
        logic [3:0] lo;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        hi = 4'($urandom_range(0, max_nib));
        lo = 4'($urandom_range(0, max_nib));
        return {hi, lo};
    endfunction

    // Mostly a request followed by a run of ticks, mixed with loose operations.
    task automatic queue_random(int count, int tick_pct, int max_nib);
        int n;
        int run_len;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                push_item(OP_REQUEST, pick_code(max_nib), 1'($urandom_range(0, 1)));
                run_len = $urandom_range(4, 40);
                repeat (run_len)
                    push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                n += run_len + 1;
            end
            else
            begin
                if ($urandom_range(0, 99) < tick_pct)
                    push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    push_item(lfcs_op_t'($urandom_range(1, 3)), pick_code(max_nib),
                              1'($urandom_range(0, 1)));
                n++;
            end
        end
    endtask

    task automatic run_phase(logic [7:0] pre, int lo, int hi, int count, int tick_pct,
                             int max_nib);
        load_settings(pre, 8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                      8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                      8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)));
        queue_random(count, tick_pct, max_nib);
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // At the reset settings, without ticks so the prescale count stays at zero.
        push_item(OP_SET_LAMP, 8'h00, 1'b1);
        push_item(OP_REQUEST, 8'h00, 1'b0);
        wait_drained();

        load_settings(8'd1, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd2);
        push_item(OP_TICK, 8'hFF, 1'b0);
        push_item(OP_SET_LAMP, 8'hFF, 1'b0);
        push_item(OP_REQUEST, 8'h11, 1'b1);
        push_item(OP_REQUEST, 8'hFF, 1'b1);
        repeat (9) push_item(OP_TICK, 8'h00, 1'b0);
        // A long flash with no short flashes goes straight to the pattern pause.
        push_item(OP_REQUEST, 8'h10, 1'b0);
        repeat (5) push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_OVERRIDE, 8'hF0, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_OVERRIDE, 8'h00, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b0);
        wait_drained();

        run_phase(8'd1, 0, 3, 250, 70, 3);
        run_phase(8'd2, 0, 0, 150, 70, 15);
        // Hold the output side long enough for the block to back up into its input.
        hold_req = 1'b1;
        run_phase(8'd3, 1, 5, 250, 70, 2);
        run_phase(8'd3, 255, 255, 200, 70, 1);
        run_phase(8'd0, 0, 2, 300, 90, 2);
        run_phase(8'd255, 0, 1, 200, 90, 1);
        // Prescale drops below the running count here, so the count wraps first.
        run_phase(8'd3, 0, 4, 250, 85, 2);

        idle_on = 1'b0;
        load_settings(8'd3, RST_LONG_ON_STEPS, RST_LONG_GAP_STEPS, RST_LONG_END_GAP_STEPS,
                      RST_SHORT_ON_STEPS, RST_SHORT_OFF_STEPS, RST_PATTERN_PAUSE_STEPS);
        queue_random(200, 80, 1);
        wait_drained();

        if (led_state_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, led_state_q.size());
            mismatch_count++;
        end
        $display("Checked %0d results across ten register settings, prescale 0 to 255.",
                 result_count);
        $display("Sequencer ran %0d steps, latched %0d codes, %0d long and %0d short flashes.",
                 step_total, latch_total, long_total, short_total);
        if (mismatch_count == 0)
            $display("** led_flash_code_sequencer: PASSED **");
        else
            $display("** led_flash_code_sequencer: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: run did not finish in time, %0d results pending",
                 $time, led_state_q.size());
        $display("** led_flash_code_sequencer: FAILED **");
        $finish;
    end

endmodule
